// ===== rtl/rvfp_pkg.sv =====
package rvfp_pkg;

  localparam logic [7:0]  START_BYTE    = 8'h01;
  localparam logic [15:0] KIND_HEART    = 16'h0A15;
  localparam logic [15:0] KIND_BREATH   = 16'h0A14;
  localparam logic [15:0] KIND_DISTANCE = 16'h0A16;

  localparam logic [15:0] LEN_RATE     = 16'd4;
  localparam logic [15:0] LEN_DISTANCE = 16'd8;
  // Frame length beyond the payload: 8 header bytes plus the payload checksum.
  localparam logic [4:0]  FRAME_OVERHEAD = 5'd9;

  localparam logic [2:0] ST_HEART    = 3'd0;
  localparam logic [2:0] ST_BREATH   = 3'd1;
  localparam logic [2:0] ST_DIST     = 3'd2;
  localparam logic [2:0] ST_NOTARGET = 3'd3;
  localparam logic [2:0] ST_HDRERR   = 3'd4;
  localparam logic [2:0] ST_PAYERR   = 3'd5;
  localparam logic [2:0] ST_UNKNOWN  = 3'd6;

  // Everything gathered about a frame by the time its last byte arrives.
  typedef struct packed {
    logic [7:0]  header_xor;
    logic [7:0]  header_sum;
    logic [15:0] type_code;
    logic [15:0] payload_length;
    logic [7:0]  payload_xor;
    logic [31:0] first_word;
    logic [31:0] second_word;
  } rvfp_frame_t;

endpackage

// ===== rtl/radar_vital_frame_parser.sv =====
// out_valid rises in the cycle after the transfer of a frame's last byte.
// Throughput: one byte per cycle; in_ready falls only while a result is held
// in the output register and out_ready is low.
// Reset (rst_n, synchronous, active low): return to hunting for the start
// byte and empty the output register.
module radar_vital_frame_parser
  import rvfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_value_bits,
  output logic [15:0] out_frame_kind
);

  // Framing control
  logic        in_frame_r, in_frame_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [4:0]  exp_len_r, exp_len_nxt;

  // Frame contents
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] type_r, type_nxt;
  logic [7:0]  hxor_r, hxor_nxt;
  logic [7:0]  pxor_r, pxor_nxt;
  logic [7:0]  hsum_r, hsum_nxt;
  logic [31:0] word1_r, word1_nxt;
  logic [31:0] word2_r, word2_nxt;

  // Output register
  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [31:0] value_r;
  logic [15:0] kind_r;

  logic        accept;
  logic        finish;
  logic [5:0]  pos_inc;
  logic [5:0]  exp_len_w;
  rvfp_frame_t frame;
  logic [2:0]  cls_status;
  logic [31:0] cls_value;

  // Take a new byte whenever the output register is free or drains this cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  assign pos_inc   = {1'b0, pos_r} + 6'd1;
  assign exp_len_w = {1'b0, exp_len_r};

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    exp_len_nxt  = exp_len_r;
    plen_nxt     = plen_r;
    type_nxt     = type_r;
    hxor_nxt     = hxor_r;
    pxor_nxt     = pxor_r;
    hsum_nxt     = hsum_r;
    word1_nxt    = word1_r;
    word2_nxt    = word2_r;
    finish       = 1'b0;

    if (!in_frame_r) begin
      // Hunt: drop everything but the start byte.
      if (in_rx_byte == START_BYTE) begin
        in_frame_nxt = 1'b1;
        pos_nxt      = 5'd1;
        exp_len_nxt  = '0;
        hxor_nxt     = in_rx_byte;
        pxor_nxt     = '0;
        word1_nxt    = '0;
        word2_nxt    = '0;
      end
    end else begin
      pos_nxt = pos_inc[4:0];
      if (pos_r >= 5'd1 && pos_r <= 5'd6) begin
        hxor_nxt = hxor_r ^ in_rx_byte;
        case (pos_r)
          5'd3: plen_nxt = {in_rx_byte, 8'h00};
          5'd4: plen_nxt = {plen_r[15:8], in_rx_byte};
          5'd5: type_nxt = {in_rx_byte, 8'h00};
          5'd6: begin
            type_nxt = {type_r[15:8], in_rx_byte};
            if (plen_r != LEN_RATE && plen_r != LEN_DISTANCE) begin
              // Unsupported length: lose sync silently.
              in_frame_nxt = 1'b0;
              pos_nxt      = '0;
              exp_len_nxt  = '0;
            end else begin
              exp_len_nxt = FRAME_OVERHEAD + plen_r[4:0];
            end
          end
          default: ;
        endcase
      end else if (pos_r == 5'd7) begin
        hsum_nxt = in_rx_byte;
      end else if (exp_len_r != '0 && pos_inc < exp_len_w) begin
        // Payload byte: fold into the XOR and place it little-endian.
        pxor_nxt = pxor_r ^ in_rx_byte;
        if (pos_r[4:2] == 3'b010) begin
          word1_nxt[pos_r[1:0]*8 +: 8] = in_rx_byte;
        end else if (pos_r[4:2] == 3'b011) begin
          word2_nxt[pos_r[1:0]*8 +: 8] = in_rx_byte;
        end
      end

      // Last byte is the payload checksum: close the frame.
      if (exp_len_r != '0 && pos_inc >= exp_len_w) begin
        finish       = 1'b1;
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        exp_len_nxt  = '0;
      end
    end
  end

  assign frame = '{
    header_xor:     hxor_r,
    header_sum:     hsum_r,
    type_code:      type_r,
    payload_length: plen_r,
    payload_xor:    pxor_r,
    first_word:     word1_r,
    second_word:    word2_r
  };

  rvfp_classify u_classify (
    .frame      (frame),
    .last_byte  (in_rx_byte),
    .status     (cls_status),
    .value_bits (cls_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      exp_len_r  <= '0;
    end else if (accept) begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      exp_len_r  <= exp_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plen_r  <= plen_nxt;
      type_r  <= type_nxt;
      hxor_r  <= hxor_nxt;
      pxor_r  <= pxor_nxt;
      hsum_r  <= hsum_nxt;
      word1_r <= word1_nxt;
      word2_r <= word2_nxt;
    end
  end

  // Hold a result until it is taken; load a new one as the old one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && finish) begin
      status_r <= cls_status;
      value_r  <= cls_value;
      kind_r   <= type_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_value_bits = value_r;
  assign out_frame_kind = kind_r;

endmodule

// ===== rtl/rvfp_classify.sv =====
module rvfp_classify
  import rvfp_pkg::*;
(
  input  rvfp_frame_t frame,
  input  logic [7:0]  last_byte,
  output logic [2:0]  status,
  output logic [31:0] value_bits
);

  logic header_ok;
  logic payload_ok;

  assign header_ok  = (~frame.header_xor) == frame.header_sum;
  assign payload_ok = (~frame.payload_xor) == last_byte;

  // Header check wins over type decode; unknown types skip the payload check.
  always_comb begin
    status     = ST_UNKNOWN;
    value_bits = '0;
    if (!header_ok) begin
      status = ST_HDRERR;
    end else if (frame.type_code == KIND_HEART || frame.type_code == KIND_BREATH) begin
      if (frame.payload_length != LEN_RATE || !payload_ok) begin
        status = ST_PAYERR;
      end else begin
        status     = (frame.type_code == KIND_HEART) ? ST_HEART : ST_BREATH;
        value_bits = frame.first_word;
      end
    end else if (frame.type_code == KIND_DISTANCE) begin
      if (frame.payload_length != LEN_DISTANCE || !payload_ok) begin
        status = ST_PAYERR;
      end else if (frame.first_word == 32'd1) begin
        status     = ST_DIST;
        value_bits = frame.second_word;
      end else begin
        status = ST_NOTARGET;
      end
    end
  end

endmodule
